### hw/rtl/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH   = 1024;
  localparam int ID_BITS = 20;
  localparam int VAL_W   = 32;
  localparam int CNT_REQ_W = 6;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  // Child indexes 2i+1 and 2i+2 need two more bits than a store address.
  localparam int IDXX_W  = ADDR_W + 2;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic [ID_BITS-1:0] id;
  } entry_t;

  // Datapath operations, one for each controller state but the two write states, which share one.
  typedef enum logic [3:0] {
    OP_ACCEPT, OP_PREAD, OP_PCMP, OP_WRITE_ITEM, OP_REJECT, OP_TOPRD,
    OP_TAILRD, OP_TAILCAP, OP_EMIT, OP_SL, OP_SR, OP_SRC, OP_SDEC
  } dp_op_t;

  typedef struct packed {
    logic push_ok;
    logic push_reject;
    logic push_root;
    logic pop_go;
    logic parent_zero;
    logic item_beats_rd;
    logic l_out;
    logic r_in;
    logic cand_beats_item;
    logic cnt_zero;
    logic remain_zero;
    logic out_free;
  } dp_status_t;

  // True when a is served before b: larger value, then earlier arrival.
  function automatic logic beats(entry_t a, entry_t b);
    beats = (a.value > b.value) || ((a.value == b.value) && (a.id < b.id));
  endfunction

endpackage

### hw/rtl/spq_ctrl.sv
module spq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_cmd,
  input  spq_pkg::dp_status_t st,
  output logic               in_ready,
  output spq_pkg::dp_op_t    op
);
  import spq_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_PREAD   = 14'b00000000000010,
    S_PCMP    = 14'b00000000000100,
    S_PWRITE  = 14'b00000000001000,
    S_REJ     = 14'b00000000010000,
    S_TOPRD   = 14'b00000000100000,
    S_TAILRD  = 14'b00000001000000,
    S_TAILCAP = 14'b00000010000000,
    S_EMIT    = 14'b00000100000000,
    S_SL      = 14'b00001000000000,
    S_SR      = 14'b00010000000000,
    S_SRC     = 14'b00100000000000,
    S_SDEC    = 14'b01000000000000,
    S_SWRITE  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op = OP_ACCEPT;
    unique case (state)
      S_IDLE: begin
        op = OP_ACCEPT;
        if (in_valid) begin
          if (in_cmd == CMD_PUSH) begin
            if (st.push_reject) state_next = S_REJ;
            else if (st.push_root) state_next = S_PWRITE;
            else state_next = S_PREAD;
          end else if (in_cmd == CMD_POP && st.pop_go) begin
            state_next = S_TOPRD;
          end
        end
      end
      S_PREAD: begin
        op = OP_PREAD;
        state_next = S_PCMP;
      end
      S_PCMP: begin
        op = OP_PCMP;
        if (st.item_beats_rd && !st.parent_zero) state_next = S_PREAD;
        else state_next = S_PWRITE;
      end
      S_PWRITE: begin
        op = OP_WRITE_ITEM;
        state_next = S_IDLE;
      end
      S_REJ: begin
        op = OP_REJECT;
        if (st.out_free) state_next = S_IDLE;
      end
      S_TOPRD: begin
        op = OP_TOPRD;
        state_next = S_TAILRD;
      end
      S_TAILRD: begin
        op = OP_TAILRD;
        state_next = S_TAILCAP;
      end
      S_TAILCAP: begin
        op = OP_TAILCAP;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        op = OP_EMIT;
        if (st.out_free) state_next = st.cnt_zero ? S_IDLE : S_SL;
      end
      S_SL: begin
        op = OP_SL;
        state_next = st.l_out ? S_SWRITE : S_SR;
      end
      S_SR: begin
        op = OP_SR;
        state_next = st.r_in ? S_SRC : S_SDEC;
      end
      S_SRC: begin
        op = OP_SRC;
        state_next = S_SDEC;
      end
      S_SDEC: begin
        op = OP_SDEC;
        state_next = st.cand_beats_item ? S_SL : S_SWRITE;
      end
      S_SWRITE: begin
        op = OP_WRITE_ITEM;
        state_next = st.remain_zero ? S_IDLE : S_TOPRD;
      end
      default: begin
        op = OP_ACCEPT;
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

### hw/rtl/spq_dp.sv
module spq_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  spq_pkg::dp_op_t                  op,
  input  logic                             in_fire,
  input  logic [1:0]                       in_cmd,
  input  logic [spq_pkg::VAL_W-1:0]        in_value,
  input  logic [spq_pkg::CNT_REQ_W-1:0]    in_count,
  input  logic                             out_ready,
  output spq_pkg::dp_status_t              st,
  output logic                             out_valid,
  output logic                             out_status,
  output logic [spq_pkg::ID_BITS-1:0]      out_id,
  output logic [spq_pkg::VAL_W-1:0]        out_value,
  output logic                             out_last
);
  import spq_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  logic [CNT_W-1:0]     cnt;
  logic [ID_BITS:0]     next_arr;
  logic [ADDR_W-1:0]    idx;
  logic [ADDR_W-1:0]    cidx;
  logic [CNT_REQ_W-1:0] remain;
  entry_t item, cand, res;

  logic [ADDR_W-1:0] pidx;
  logic [IDXX_W-1:0] lidx, ridx, cnt_x;
  logic              out_free;
  logic              out_load;

  assign pidx  = (idx - ADDR_W'(1)) >> 1;
  assign lidx  = {1'b0, idx, 1'b0} + IDXX_W'(1);
  assign ridx  = {1'b0, idx, 1'b0} + IDXX_W'(2);
  assign cnt_x = {{(IDXX_W-CNT_W){1'b0}}, cnt};
  assign out_free = !out_valid || out_ready;
  // The output register takes a new beat in either of the two emitting steps.
  assign out_load = ((op == OP_REJECT) || (op == OP_EMIT)) && out_free;

  assign st.push_reject     = (cnt == CNT_W'(DEPTH)) || next_arr[ID_BITS];
  assign st.push_ok         = !st.push_reject;
  assign st.push_root       = (cnt == '0);
  assign st.pop_go          = (in_count != '0) && (cnt != '0);
  assign st.parent_zero     = (pidx == '0);
  assign st.item_beats_rd   = beats(item, rd_data);
  assign st.l_out           = (lidx >= cnt_x);
  assign st.r_in            = (ridx < cnt_x);
  assign st.cand_beats_item = beats(cand, item);
  assign st.cnt_zero        = (cnt == '0);
  assign st.remain_zero     = (remain == '0);
  assign st.out_free        = out_free;

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = item;
    unique case (op)
      OP_PREAD:      rd_addr = pidx;
      OP_TAILRD:     rd_addr = ADDR_W'(cnt - CNT_W'(1));
      OP_SL:         rd_addr = lidx[ADDR_W-1:0];
      OP_SR:         rd_addr = ridx[ADDR_W-1:0];
      OP_PCMP: begin
        wr_en   = st.item_beats_rd;
        wr_data = rd_data;
      end
      OP_SDEC: begin
        wr_en   = st.cand_beats_item;
        wr_data = cand;
      end
      OP_WRITE_ITEM: wr_en = 1'b1;
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      next_arr  <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (op)
        OP_ACCEPT: begin
          if (in_fire) begin
            if (in_cmd == CMD_PUSH && st.push_ok) begin
              item     <= '{value: in_value, id: next_arr[ID_BITS-1:0]};
              idx      <= cnt[ADDR_W-1:0];
              cnt      <= cnt + CNT_W'(1);
              next_arr <= next_arr + 1'b1;
            end else if (in_cmd == CMD_POP) begin
              remain <= in_count;
            end else if (in_cmd == CMD_CLEAR) begin
              cnt      <= '0;
              next_arr <= '0;
            end
          end
        end
        OP_PCMP: if (st.item_beats_rd) idx <= pidx;
        OP_REJECT: begin
          if (out_free) begin
            out_status <= 1'b1;
            out_id     <= '0;
            out_value  <= '0;
            out_last   <= 1'b1;
          end
        end
        OP_TAILRD: res <= rd_data;
        OP_TAILCAP: begin
          item <= rd_data;
          cnt  <= cnt - CNT_W'(1);
          idx  <= '0;
        end
        OP_EMIT: begin
          if (out_free) begin
            out_status <= 1'b0;
            out_id     <= res.id;
            out_value  <= res.value;
            out_last   <= (remain == CNT_REQ_W'(1)) || (cnt == '0);
            remain     <= remain - CNT_REQ_W'(1);
          end
        end
        OP_SR: begin
          cand <= rd_data;
          cidx <= lidx[ADDR_W-1:0];
        end
        OP_SRC: begin
          if (beats(rd_data, cand)) begin
            cand <= rd_data;
            cidx <= ridx[ADDR_W-1:0];
          end
        end
        OP_SDEC: if (st.cand_beats_item) idx <= cidx;
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/stable_priority_queue.sv
// Stable max priority queue over a binary heap of DEPTH entries in one
// single-port-read RAM. Commands arrive one beat at a time and are taken
// only while the controller is idle. A push reads and compares each parent
// in turn, moving it down while the new entry beats it, then writes the
// entry; each entry served by a pop fetches the root and the tail, emits the
// root, then sifts the tail down, reading both children one after the other
// through the one RAM read port, and writes it where it settles. Clear and
// ignored commands leave the controller idle. Served entries and push
// rejects leave through an output register, so the heap work continues
// while a beat waits.
module stable_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // Fields from bit 0: command[1:0], priority_value[33:2], count[39:34].
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // Fields from bit 0: entry_id[19:0], entry_value[51:20], zero fill.
  output logic [55:0] m_tdata,
  // Field: status (1 means the push was rejected).
  output logic        m_tuser,
  output logic        m_tlast
);
  import spq_pkg::*;

  dp_op_t             op;
  dp_status_t         st;
  logic               in_fire;
  logic [ID_BITS-1:0] out_id;
  logic [VAL_W-1:0]   out_value;

  assign in_fire = s_tvalid && s_tready;

  // The controller only sequences; every index and compare lives in the
  // datapath.
  spq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_cmd   (s_tdata[1:0]),
    .st       (st),
    .in_ready (s_tready),
    .op       (op)
  );

  spq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .in_fire    (in_fire),
    .in_cmd     (s_tdata[1:0]),
    .in_value   (s_tdata[33:2]),
    .in_count   (s_tdata[39:34]),
    .out_ready  (m_tready),
    .st         (st),
    .out_valid  (m_tvalid),
    .out_status (m_tuser),
    .out_id     (out_id),
    .out_value  (out_value),
    .out_last   (m_tlast)
  );

  assign m_tdata = {4'b0, out_value, out_id};

  // A reject beat is always the only beat of its command.
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("reject beat without last");

  // A clear leaves an empty store.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tdata[1:0] == CMD_CLEAR |=> st.cnt_zero)
    else $error("store not empty after clear");

  // A push onto a full store is rejected, never stored.
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    in_fire && s_tdata[1:0] == CMD_PUSH && st.push_reject |=> !s_tready)
    else $error("rejected push did not report");

endmodule
